@@ rtl/sha1md_pkg.sv @@
package sha1md_pkg;

   localparam int WORD_W      = 32;
   localparam int NUM_WORDS   = 5;
   localparam int ROUNDS      = 80;
   localparam int ROUND_W     = 7;
   localparam int BLOCK_BYTES = 64;
   localparam int BLOCK_BITS  = BLOCK_BYTES * 8;
   localparam int FILL_W      = 6;
   localparam int LEN_POS     = 56;
   localparam int INDEX_W     = 3;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
      word_type e;
   } work_type;

   // Schedule taps relative to the oldest word of the sixteen-word window.
   typedef struct packed {
      word_type s0;
      word_type s2;
      word_type s8;
      word_type s13;
   } taps_type;

   localparam word_type INIT_H [0:NUM_WORDS-1] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam word_type K_CH  = 32'h5A827999;
   localparam word_type K_P1  = 32'h6ED9EBA1;
   localparam word_type K_MAJ = 32'h8F1BBCDC;
   localparam word_type K_P2  = 32'hCA62C1D6;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   function automatic word_type rotl(word_type v, int unsigned s);
      return (v << s) | (v >> (WORD_W - s));
   endfunction

endpackage

@@ rtl/sha1md_round.sv @@
module sha1md_round (
   input  logic [sha1md_pkg::ROUND_W-1:0] round_i,
   input  sha1md_pkg::work_type           work_i,
   input  sha1md_pkg::taps_type           taps_i,
   output sha1md_pkg::word_type           w_o,
   output sha1md_pkg::work_type           work_o
);
   import sha1md_pkg::*;

   word_type f;
   word_type k;
   word_type sum;

   always_comb begin
      // The first sixteen rounds use the block words as they stand.
      if (round_i < ROUND_W'(16)) begin
         w_o = taps_i.s0;
      end else begin
         w_o = rotl(taps_i.s13 ^ taps_i.s8 ^ taps_i.s2 ^ taps_i.s0, 1);
      end

      if (round_i < ROUND_W'(20)) begin
         f = (work_i.b & work_i.c) | (~work_i.b & work_i.d);
         k = K_CH;
      end else if (round_i < ROUND_W'(40)) begin
         f = work_i.b ^ work_i.c ^ work_i.d;
         k = K_P1;
      end else if (round_i < ROUND_W'(60)) begin
         f = (work_i.b & work_i.c) | (work_i.b & work_i.d) | (work_i.c & work_i.d);
         k = K_MAJ;
      end else begin
         f = work_i.b ^ work_i.c ^ work_i.d;
         k = K_P2;
      end

      sum = rotl(work_i.a, 5) + f + work_i.e + k + w_o;

      work_o.a = sum;
      work_o.b = work_i.a;
      work_o.c = rotl(work_i.b, 30);
      work_o.d = work_i.c;
      work_o.e = work_i.d;
   end

endmodule

@@ rtl/sha1_message_digest.sv @@
// Streaming SHA-1 digest engine. Each accepted request carries at most one
// message byte (req_byte_valid) and may close the message (req_end_of_message);
// a request that closes the message without a byte finishes it as it stands,
// so an empty message is allowed. A byte that neither completes a block nor
// closes the message is taken without a stall. When a byte completes a 64-byte
// block, req_stall stays high while the single shared round unit runs the 80
// rounds, one per cycle, and then while the chaining value is updated. Closing
// a message costs a padding pass that shifts one pad byte per cycle up to the
// end of the block, then one compression, or two passes and two compressions
// when over 55 bytes were pending in the last block. The digest leaves as five
// responses, h0 first, one per cycle unless the receiver stalls; after the
// fifth the engine starts over for the next message. The message length is
// counted modulo 2^64 bytes and written as bits, big-endian, in the pad.
module sha1_message_digest (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import sha1md_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_ROUND  = 3'd1;
   localparam logic [2:0] ST_FINISH = 3'd2;
   localparam logic [2:0] ST_PAD    = 3'd3;
   localparam logic [2:0] ST_OUT    = 3'd4;

   localparam int TAP0  = BLOCK_BITS - 1;
   localparam int TAP2  = BLOCK_BITS - 1 - 2 * WORD_W;
   localparam int TAP8  = BLOCK_BITS - 1 - 8 * WORD_W;
   localparam int TAP13 = BLOCK_BITS - 1 - 13 * WORD_W;

   logic [2:0]            state_ff, state_in;
   logic [63:0]           count_ff, count_in;
   logic [63:0]           len_ff, len_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic                  pad_first_ff, pad_first_in;
   logic                  len_ok_ff, len_ok_in;
   logic                  pad_active_ff, pad_active_in;
   logic                  final_ff, final_in;
   logic [ROUND_W-1:0]    round_ff, round_in;
   logic [INDEX_W-1:0]    idx_ff, idx_in;
   logic [BLOCK_BITS-1:0] buf_ff, buf_in;
   work_type              work_ff, work_in;
   word_type              chain_ff [0:NUM_WORDS-1];
   word_type              chain_in [0:NUM_WORDS-1];

   logic                  req_accept;
   logic [63:0]           count_next;
   logic [7:0]            pad_byte;
   logic                  len_byte;
   taps_type              taps;
   word_type              w_cur;
   work_type              work_next;
   work_type              work_start;

   // The block buffer doubles as the sixteen-word schedule window: bytes shift
   // in at the bottom, and during compression words rotate out of the top.
   assign taps.s0  = buf_ff[TAP0  -: WORD_W];
   assign taps.s2  = buf_ff[TAP2  -: WORD_W];
   assign taps.s8  = buf_ff[TAP8  -: WORD_W];
   assign taps.s13 = buf_ff[TAP13 -: WORD_W];

   sha1md_round u_round (
      .round_i (round_ff),
      .work_i  (work_ff),
      .taps_i  (taps),
      .w_o     (w_cur),
      .work_o  (work_next)
   );

   assign work_start.a = chain_ff[0];
   assign work_start.b = chain_ff[1];
   assign work_start.c = chain_ff[2];
   assign work_start.d = chain_ff[3];
   assign work_start.e = chain_ff[4];

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign count_next = count_ff + 64'(req_byte_valid);

   // The length bytes follow the 0x80 marker if it left room, else go into the next block.
   assign len_byte = len_ok_ff && !pad_first_ff && (fill_ff >= FILL_W'(LEN_POS));

   always_comb begin
      if (pad_first_ff) begin
         pad_byte = PAD_BYTE;
      end else if (len_byte) begin
         pad_byte = len_ff[63:56];
      end else begin
         pad_byte = 8'h00;
      end
   end

   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_digest_word = chain_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == INDEX_W'(NUM_WORDS - 1));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      len_in        = len_ff;
      fill_in       = fill_ff;
      pad_first_in  = pad_first_ff;
      len_ok_in     = len_ok_ff;
      pad_active_in = pad_active_ff;
      final_in      = final_ff;
      round_in      = round_ff;
      idx_in        = idx_ff;
      buf_in        = buf_ff;
      work_in       = work_ff;
      chain_in      = chain_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_byte_valid) begin
                  buf_in   = {buf_ff[BLOCK_BITS-9:0], req_data_byte};
                  count_in = count_next;
               end
               pad_active_in = req_end_of_message;
               len_in        = {count_next[60:0], 3'b000};
               fill_in       = count_next[FILL_W-1:0];
               pad_first_in  = 1'b1;
               len_ok_in     = 1'b0;
               final_in      = 1'b0;
               if (req_byte_valid && (count_ff[FILL_W-1:0] == FILL_W'(BLOCK_BYTES - 1))) begin
                  state_in = ST_ROUND;
                  round_in = '0;
                  work_in  = work_start;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            work_in  = work_next;
            buf_in   = {buf_ff[BLOCK_BITS-WORD_W-1:0], w_cur};
            round_in = round_ff + 1'b1;
            if (round_ff == ROUND_W'(ROUNDS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            chain_in[0] = chain_ff[0] + work_ff.a;
            chain_in[1] = chain_ff[1] + work_ff.b;
            chain_in[2] = chain_ff[2] + work_ff.c;
            chain_in[3] = chain_ff[3] + work_ff.d;
            chain_in[4] = chain_ff[4] + work_ff.e;
            if (final_ff) begin
               state_in = ST_OUT;
               idx_in   = '0;
            end else if (pad_active_ff) begin
               // A block ended before the marker left room, so the next one
               // carries the length.
               state_in  = ST_PAD;
               len_ok_in = !pad_first_ff;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            buf_in       = {buf_ff[BLOCK_BITS-9:0], pad_byte};
            fill_in      = fill_ff + 1'b1;
            pad_first_in = 1'b0;
            if (pad_first_ff) begin
               len_ok_in = (fill_ff < FILL_W'(LEN_POS));
            end
            if (len_byte) begin
               len_in = {len_ff[55:0], 8'h00};
            end
            if (fill_ff == FILL_W'(BLOCK_BYTES - 1)) begin
               final_in = len_ok_ff && !pad_first_ff;
               state_in = ST_ROUND;
               round_in = '0;
               work_in  = work_start;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               if (idx_ff == INDEX_W'(NUM_WORDS - 1)) begin
                  chain_in      = INIT_H;
                  count_in      = '0;
                  pad_active_in = 1'b0;
                  final_in      = 1'b0;
                  state_in      = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         fill_ff       <= '0;
         pad_first_ff  <= 1'b0;
         len_ok_ff     <= 1'b0;
         pad_active_ff <= 1'b0;
         final_ff      <= 1'b0;
         round_ff      <= '0;
         idx_ff        <= '0;
         chain_ff      <= INIT_H;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         fill_ff       <= fill_in;
         pad_first_ff  <= pad_first_in;
         len_ok_ff     <= len_ok_in;
         pad_active_ff <= pad_active_in;
         final_ff      <= final_in;
         round_ff      <= round_in;
         idx_ff        <= idx_in;
         chain_ff      <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      buf_ff  <= buf_in;
      work_ff <= work_in;
   end

endmodule
